>>> rtl/core/ocgd_pkg.sv
// Package for the occupancy counter with gate pulse and two-digit display.
// Holds widths, reset values, register indexes, the segment font and the digit split.
// Used by the output channel interface and the top level; depends on nothing.
`default_nettype none

package ocgd_pkg;

    localparam int CountW = 7;
    localparam int TimerW = 8;
    localparam int SegW   = 7;
    localparam int DigitW = 4;

    // Largest count that two digits can show.
    localparam logic [CountW-1:0] DisplayMax = 7'd99;

    // Register reset values.
    localparam logic [CountW-1:0] MaxCountRst     = 7'd99;
    localparam logic [TimerW-1:0] EntryLockoutRst = 8'd25;
    localparam logic [TimerW-1:0] ExitLockoutRst  = 8'd25;
    localparam logic [TimerW-1:0] GatePulseRst    = 8'd250;

    // Configuration port.
    localparam int CfgIdxW  = 2;
    localparam int CfgDataW = 8;

    typedef enum logic [CfgIdxW-1:0] {
        CFG_MAX_COUNT     = 2'd0,
        CFG_ENTRY_LOCKOUT = 2'd1,
        CFG_EXIT_LOCKOUT  = 2'd2,
        CFG_GATE_PULSE    = 2'd3
    } t_cfg_reg;

    // Digit enable latch: bit 0 is the tens enable, bit 1 the units enable, low is on.
    typedef logic [1:0] t_enables;
    localparam t_enables EnOff   = 2'b11;
    localparam t_enables EnTens  = 2'b10;
    localparam t_enables EnUnits = 2'b01;

    // Common-cathode font, bit 0 is segment a.
    localparam logic [SegW-1:0] SegFont [10] = '{
        7'h3F, 7'h06, 7'h5B, 7'h4F, 7'h66, 7'h6D, 7'h7D, 7'h07, 7'h7F, 7'h6F
    };

    // Tens digit of a count up to 99 by reciprocal multiplication (205 / 2048).
    function automatic logic [DigitW-1:0] tens_of(input logic [CountW-1:0] c);
        logic [17:0] prod;
        prod = {11'd0, c} * 18'd205;
        return prod[14:11];
    endfunction

    // Units digit: the count less ten times its tens digit.
    function automatic logic [DigitW-1:0] units_of(input logic [CountW-1:0] c);
        logic [DigitW-1:0] t;
        logic [CountW-1:0] t10;
        t   = tens_of(c);
        t10 = {t, 3'd0} + {2'd0, t, 1'd0};
        return DigitW'(c - t10);
    endfunction

endpackage

`default_nettype wire

>>> rtl/core/ocgd_in_if.sv
// Input channel: one word carries the tick flag and the two sensor events.
// Valid/ready handshake; depends on nothing.
`default_nettype none

interface ocgd_in_if;
    logic valid;
    logic ready;
    logic tick;
    logic entry_event;
    logic exit_event;

    modport source (output valid, output tick, output entry_event, output exit_event,
                    input ready);
    modport sink   (input valid, input tick, input entry_event, input exit_event,
                    output ready);
endinterface

`default_nettype wire

>>> rtl/core/ocgd_out_if.sv
// Output channel: one word carries the display latches, the gate and the count.
// Valid/ready handshake; widths come from ocgd_pkg.
`default_nettype none

interface ocgd_out_if;
    logic                            valid;
    logic                            ready;
    logic [ocgd_pkg::SegW-1:0]       segments;
    logic                            tens_enable_n;
    logic                            units_enable_n;
    logic                            gate_on;
    logic [ocgd_pkg::CountW-1:0]     occupancy;

    modport source (output valid, output segments, output tens_enable_n,
                    output units_enable_n, output gate_on, output occupancy,
                    input ready);
    modport sink   (input valid, input segments, input tens_enable_n,
                    input units_enable_n, input gate_on, input occupancy,
                    output ready);
endinterface

`default_nettype wire

>>> rtl/core/occupancy_counter_gate_display_top.sv
// Top level of the occupancy counter with gate pulse and two-digit display.
// Depends on ocgd_pkg, ocgd_in_if and ocgd_out_if.
//
// Usage:
//   i_in carries one word per event pattern: tick, entry_event, exit_event.
//   o_out returns exactly one word per input word: the latched segments,
//   the two active-low digit enables, the gate output and the count.
//   The configuration port writes max_count, entry and exit lockout lengths
//   and the gate pulse length; write it only while no word is in flight.
// Timing:
//   A word sits in the input register, then the state update and the result
//   are written together into the result registers, which drive o_out.
//   One word per cycle is sustained while o_out is taken; the rate is set
//   by the single update stage between input register and result registers.
// Stalls:
//   While o_out is held, the input register still takes one more word; after
//   that i_in.ready drops until the result is taken.
// Reset:
//   i_rst_n is synchronous, active low. The count, timers and gate clear,
//   both digits are off, tens is shown first, registers take their defaults.
`default_nettype none

module occupancy_counter_gate_display_top (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    ocgd_in_if.sink                              i_in,
    ocgd_out_if.source                           o_out,
    input  wire logic                            i_cfg_we,
    input  wire logic [ocgd_pkg::CfgIdxW-1:0]    i_cfg_index,
    input  wire logic [ocgd_pkg::CfgDataW-1:0]   i_cfg_data
);

    localparam int CW = ocgd_pkg::CountW;
    localparam int TW = ocgd_pkg::TimerW;
    localparam int SW = ocgd_pkg::SegW;

    // Configuration registers.
    logic [CW-1:0] r_max_count;
    logic [TW-1:0] r_entry_lockout;
    logic [TW-1:0] r_exit_lockout;
    logic [TW-1:0] r_gate_pulse;

    // Input register.
    logic r_s1_valid;
    logic r_s1_tick;
    logic r_s1_entry;
    logic r_s1_exit;

    // Block state; the latches double as the result register.
    logic [CW-1:0]            r_count,      n_count;
    logic [TW-1:0]            r_gate_timer, n_gate_timer;
    logic [TW-1:0]            r_entry_lock, n_entry_lock;
    logic [TW-1:0]            r_exit_lock,  n_exit_lock;
    logic                     r_digit_sel,  n_digit_sel;
    logic [SW-1:0]            r_seg_latch,  n_seg_latch;
    ocgd_pkg::t_enables       r_en_latch,   n_en_latch;
    logic                     r_gate_latch, n_gate_latch;
    logic                     r_out_valid;

    logic in_fire;
    logic s1_fire;

    // Handshake: the update stage moves when the result slot is free or being taken.
    assign s1_fire    = r_s1_valid && (!r_out_valid || o_out.ready);
    assign i_in.ready = !r_s1_valid || s1_fire;
    assign in_fire    = i_in.valid && i_in.ready;

    // State update for the word in the input register.
    always_comb begin
        logic [CW-1:0]                top;
        logic [CW-1:0]                shown;
        logic [ocgd_pkg::DigitW-1:0]  digit;
        logic                         moved;

        n_count      = r_count;
        n_gate_timer = r_gate_timer;
        n_entry_lock = r_entry_lock;
        n_exit_lock  = r_exit_lock;
        n_digit_sel  = r_digit_sel;
        n_seg_latch  = r_seg_latch;
        n_en_latch   = r_en_latch;
        n_gate_latch = r_gate_latch;
        moved        = 1'b0;

        top   = (r_max_count > ocgd_pkg::DisplayMax) ? ocgd_pkg::DisplayMax : r_max_count;
        shown = (r_count > ocgd_pkg::DisplayMax) ? ocgd_pkg::DisplayMax : r_count;
        digit = r_digit_sel ? ocgd_pkg::units_of(shown) : ocgd_pkg::tens_of(shown);

        // The tick runs the timers down and shows the next digit of the old count.
        if (r_s1_tick) begin
            if (r_gate_timer != '0) begin
                n_gate_timer = r_gate_timer - 1'b1;
                if (r_gate_timer == TW'(1)) begin
                    n_gate_latch = 1'b0;
                end
            end
            if (r_entry_lock != '0) begin
                n_entry_lock = r_entry_lock - 1'b1;
            end
            if (r_exit_lock != '0) begin
                n_exit_lock = r_exit_lock - 1'b1;
            end
            n_seg_latch = (digit > 4'd9) ? ocgd_pkg::SegFont[0] : ocgd_pkg::SegFont[digit];
            n_en_latch  = r_digit_sel ? ocgd_pkg::EnUnits : ocgd_pkg::EnTens;
            n_digit_sel = !r_digit_sel;
        end

        // Entry is taken before exit; both may move the count in one word.
        if (r_s1_entry && n_entry_lock == '0) begin
            n_entry_lock = r_entry_lockout;
            if (n_count < top) begin
                n_count = n_count + 1'b1;
                moved   = 1'b1;
            end
        end
        if (r_s1_exit && n_exit_lock == '0) begin
            n_exit_lock = r_exit_lockout;
            if (n_count != '0) begin
                n_count = n_count - 1'b1;
                moved   = 1'b1;
            end
        end

        // A count move restarts the gate pulse.
        if (moved) begin
            n_gate_timer = r_gate_pulse;
            n_gate_latch = (r_gate_pulse != '0);
        end
    end

    // Configuration writes.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max_count     <= ocgd_pkg::MaxCountRst;
            r_entry_lockout <= ocgd_pkg::EntryLockoutRst;
            r_exit_lockout  <= ocgd_pkg::ExitLockoutRst;
            r_gate_pulse    <= ocgd_pkg::GatePulseRst;
        end else if (i_cfg_we) begin
            unique case (ocgd_pkg::t_cfg_reg'(i_cfg_index))
                ocgd_pkg::CFG_MAX_COUNT:     r_max_count     <= i_cfg_data[CW-1:0];
                ocgd_pkg::CFG_ENTRY_LOCKOUT: r_entry_lockout <= i_cfg_data[TW-1:0];
                ocgd_pkg::CFG_EXIT_LOCKOUT:  r_exit_lockout  <= i_cfg_data[TW-1:0];
                ocgd_pkg::CFG_GATE_PULSE:    r_gate_pulse    <= i_cfg_data[TW-1:0];
                default: ;
            endcase
        end
    end

    // Input register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (in_fire) begin
            r_s1_valid <= 1'b1;
        end else if (s1_fire) begin
            r_s1_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_fire) begin
            r_s1_tick  <= i_in.tick;
            r_s1_entry <= i_in.entry_event;
            r_s1_exit  <= i_in.exit_event;
        end
    end

    // State and result registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count      <= '0;
            r_gate_timer <= '0;
            r_entry_lock <= '0;
            r_exit_lock  <= '0;
            r_digit_sel  <= 1'b0;
            r_seg_latch  <= '0;
            r_en_latch   <= ocgd_pkg::EnOff;
            r_gate_latch <= 1'b0;
            r_out_valid  <= 1'b0;
        end else begin
            if (s1_fire) begin
                r_count      <= n_count;
                r_gate_timer <= n_gate_timer;
                r_entry_lock <= n_entry_lock;
                r_exit_lock  <= n_exit_lock;
                r_digit_sel  <= n_digit_sel;
                r_seg_latch  <= n_seg_latch;
                r_en_latch   <= n_en_latch;
                r_gate_latch <= n_gate_latch;
                r_out_valid  <= 1'b1;
            end else if (o_out.ready) begin
                r_out_valid  <= 1'b0;
            end
        end
    end

    assign o_out.valid          = r_out_valid;
    assign o_out.segments       = r_seg_latch;
    assign o_out.tens_enable_n  = r_en_latch[0];
    assign o_out.units_enable_n = r_en_latch[1];
    assign o_out.gate_on        = r_gate_latch;
    assign o_out.occupancy      = r_count;

`ifndef NO_ASSERTIONS
    // The count never leaves the two-digit range.
    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= ocgd_pkg::DisplayMax)
        else $error("occupancy count above display range");

    // The gate is on only while its timer still runs.
    a_gate_timer: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_gate_latch |-> (r_gate_timer != '0))
        else $error("gate on with expired timer");

    // At most one digit is enabled.
    a_one_digit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_en_latch != 2'b00)
        else $error("both digits enabled");

    // A held result with a full input register blocks the input.
    a_backpressure: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_s1_valid && r_out_valid && !o_out.ready) |-> !i_in.ready)
        else $error("input taken while both stages are full");

    // A word without a tick, moved count or not, carries the display latches unchanged.
    a_display_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s1_fire && !r_s1_tick) |=> $stable(r_seg_latch) && $stable(r_en_latch))
        else $error("display changed without a tick");
`endif

endmodule

`default_nettype wire

>>> verif/tb.sv
// Self-checking bench for occupancy_counter_gate_display_top.
// Drives random and directed event words with random pacing on both channels and checks
// every result word against an in-bench predictor. Needs ocgd_pkg, ocgd_in_if, ocgd_out_if.
`default_nettype none

module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import ocgd_pkg::*;

    localparam int ClkPeriod  = 12;
    localparam int CycleLimit = 300000;

    // Seven-segment patterns for digits 0 to 9, bit 0 is segment a.
    localparam logic [SegW-1:0] DigitFont [10] = '{
        7'h3F, 7'h06, 7'h5B, 7'h4F, 7'h66, 7'h6D, 7'h7D, 7'h07, 7'h7F, 7'h6F
    };

    // How a channel side spaces its handshakes.
    typedef enum int {PACE_FULL, PACE_RANDOM, PACE_BURSTY} t_pace;

    // One result word as the block presents it.
    typedef struct packed {
        logic [SegW-1:0]   segments;
        logic              tens_n;
        logic              units_n;
        logic              gate;
        logic [CountW-1:0] occupancy;
    } t_display_word;

    logic i_clk = 1'b0;
    logic i_rst_n;
    logic i_cfg_we;
    logic [CfgIdxW-1:0]  i_cfg_index;
    logic [CfgDataW-1:0] i_cfg_data;

    ocgd_in_if  in_ch ();
    ocgd_out_if out_ch ();

    occupancy_counter_gate_display_top u_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in        (in_ch),
        .o_out       (out_ch),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    always #(ClkPeriod / 2) i_clk = ~i_clk;

    // Predictor copy of the configuration registers.
    logic [CountW-1:0] cfg_max_count;
    logic [TimerW-1:0] cfg_entry_lockout;
    logic [TimerW-1:0] cfg_exit_lockout;
    logic [TimerW-1:0] cfg_gate_pulse;

    // Predictor copy of the counter, timers and display latches.
    logic [CountW-1:0] occ_count;
    logic [TimerW-1:0] gate_left;
    logic [TimerW-1:0] entry_left;
    logic [TimerW-1:0] exit_left;
    logic              show_units;
    logic [SegW-1:0]   seg_shown;
    t_enables          digit_en;
    logic              gate_state;

    t_display_word pending_display_words [$];

    t_pace tx_pace = PACE_FULL;
    t_pace rx_pace = PACE_FULL;
    int    rx_wait = 0;
    logic  rx_hold = 1'b0;

    int errors          = 0;
    int words_sent      = 0;
    int words_checked   = 0;
    int settings_loaded = 0;
    int peak_occupancy  = 0;
    int cycles          = 0;

    function automatic int draw_gap(input t_pace pace);
        case (pace)
            PACE_FULL:   return 0;
            PACE_RANDOM: return $urandom_range(0, 12);
            default:     return ($urandom_range(0, 3) == 0) ? $urandom_range(1, 12) : 0;
        endcase
    endfunction

    function automatic logic roll(input int pct);
        return $urandom_range(0, 99) < pct;
    endfunction

    // Mostly short timer lengths so that events get through, now and then any length.
    function automatic int draw_ticks();
        return ($urandom_range(0, 3) == 0) ? $urandom_range(0, 255) : $urandom_range(0, 6);
    endfunction

    // Apply one accepted event word to the predicted state and queue the result word.
    task automatic advance_counter(input logic tick, input logic entry, input logic leave);
        logic [CountW-1:0] top_count;
        logic [DigitW-1:0] digit;
        logic              moved;
        t_display_word     w;
        top_count = (cfg_max_count > DisplayMax) ? DisplayMax : cfg_max_count;
        moved = 1'b0;
        // The tick runs first, so the display shows the count from before this word.
        if (tick) begin
            if (gate_left != 0) begin
                gate_left--;
                if (gate_left == 0) gate_state = 1'b0;
            end
            if (entry_left != 0) entry_left--;
            if (exit_left != 0) exit_left--;
            digit = show_units ? DigitW'(occ_count % 10) : DigitW'(occ_count / 10);
            seg_shown = DigitFont[digit];
            digit_en = show_units ? EnUnits : EnTens;
            show_units = ~show_units;
        end
        if (entry && entry_left == 0) begin
            entry_left = cfg_entry_lockout;
            if (occ_count < top_count) begin
                occ_count++;
                moved = 1'b1;
            end
        end
        if (leave && exit_left == 0) begin
            exit_left = cfg_exit_lockout;
            if (occ_count > 0) begin
                occ_count--;
                moved = 1'b1;
            end
        end
        // Any count change restarts the gate pulse; a zero length keeps the gate off.
        if (moved) begin
            gate_left = cfg_gate_pulse;
            gate_state = (cfg_gate_pulse != 0);
        end
        if (occ_count > peak_occupancy) peak_occupancy = occ_count;
        w.segments  = seg_shown;
        w.tens_n    = digit_en[0];
        w.units_n   = digit_en[1];
        w.gate      = gate_state;
        w.occupancy = occ_count;
        pending_display_words.push_back(w);
    endtask

    // Offer one event word after the sender's gap and wait for the handshake.
    task automatic drive_word(input logic tick, input logic entry, input logic leave);
        int gap;
        gap = draw_gap(tx_pace);
        if (gap > 0) begin
            @(negedge i_clk);
            in_ch.valid <= 1'b0;
            repeat (gap - 1) @(negedge i_clk);
        end
        @(negedge i_clk);
        in_ch.valid       <= 1'b1;
        in_ch.tick        <= tick;
        in_ch.entry_event <= entry;
        in_ch.exit_event  <= leave;
        @(posedge i_clk);
        while (in_ch.ready !== 1'b1) @(posedge i_clk);
        words_sent++;
        advance_counter(tick, entry, leave);
    endtask

    task automatic stop_input();
        @(negedge i_clk);
        in_ch.valid <= 1'b0;
    endtask

    // Wait until every expected word is back, then allow for the two-stage latency.
    task automatic settle_block();
        while (pending_display_words.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic put_reg(input t_cfg_reg sel, input logic [CfgDataW-1:0] data);
        @(negedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= sel;
        i_cfg_data  <= data;
        @(posedge i_clk);
        case (sel)
            CFG_MAX_COUNT:     cfg_max_count     = data[CountW-1:0];
            CFG_ENTRY_LOCKOUT: cfg_entry_lockout = data;
            CFG_EXIT_LOCKOUT:  cfg_exit_lockout  = data;
            default:           cfg_gate_pulse    = data;
        endcase
    endtask

    // Write all four registers while the block is idle.
    task automatic load_settings(input int max_c, input int ent_lo, input int ext_lo,
                                 input int pulse);
        settle_block();
        put_reg(CFG_MAX_COUNT, CfgDataW'(max_c));
        put_reg(CFG_ENTRY_LOCKOUT, CfgDataW'(ent_lo));
        put_reg(CFG_EXIT_LOCKOUT, CfgDataW'(ext_lo));
        put_reg(CFG_GATE_PULSE, CfgDataW'(pulse));
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
        settings_loaded++;
    endtask

    task automatic run_phase(input int words, input int max_c, input int ent_lo,
                             input int ext_lo, input int pulse, input int pct_tick,
                             input int pct_entry, input int pct_leave,
                             input t_pace tx, input t_pace rx);
        load_settings(max_c, ent_lo, ext_lo, pulse);
        tx_pace = tx;
        rx_pace = rx;
        repeat (words) drive_word(roll(pct_tick), roll(pct_entry), roll(pct_leave));
        stop_input();
    endtask

    // Reset settings: idle word, first tick, exit at zero, entry, then lockouts hold both.
    task automatic test_defaults_after_reset();
        drive_word(1'b0, 1'b0, 1'b0);
        drive_word(1'b1, 1'b0, 1'b0);
        drive_word(1'b0, 1'b0, 1'b1);
        drive_word(1'b0, 1'b1, 1'b0);
        drive_word(1'b1, 1'b1, 1'b1);
        stop_input();
    endtask

    // Short lockouts and pulses: gate expiry on a tick, lockout release, zero pulse.
    task automatic test_lockout_and_pulse();
        load_settings(99, 2, 0, 1);
        drive_word(1'b0, 1'b1, 1'b1);
        drive_word(1'b0, 1'b1, 1'b0);
        drive_word(1'b1, 1'b0, 1'b0);
        drive_word(1'b0, 1'b1, 1'b0);
        drive_word(1'b1, 1'b1, 1'b0);
        stop_input();
        load_settings(99, 0, 0, 0);
        drive_word(1'b0, 1'b1, 1'b0);
        drive_word(1'b1, 1'b1, 1'b1);
        drive_word(1'b1, 1'b0, 1'b0);
        stop_input();
    endtask

    // Limits: maximum of zero, the top data bit, saturation at a maximum of one.
    task automatic test_count_limits();
        load_settings(0, 0, 0, 5);
        drive_word(1'b0, 1'b1, 1'b0);
        drive_word(1'b0, 1'b0, 1'b1);
        drive_word(1'b1, 1'b1, 1'b0);
        stop_input();
        load_settings(8'hFF, 0, 0, 255);
        drive_word(1'b0, 1'b1, 1'b0);
        drive_word(1'b0, 1'b0, 1'b1);
        drive_word(1'b0, 1'b0, 1'b1);
        drive_word(1'b0, 1'b0, 1'b1);
        drive_word(1'b1, 1'b0, 1'b0);
        stop_input();
        load_settings(1, 0, 0, 2);
        drive_word(1'b0, 1'b1, 1'b0);
        drive_word(1'b0, 1'b1, 1'b0);
        drive_word(1'b1, 1'b0, 1'b0);
        stop_input();
    endtask

    // Random event words under a spread of settings and pacing.
    task automatic test_random_traffic();
        // Fill to the display maximum with a maximum of 127, above the display range.
        run_phase(260, 8'h7F, 0, 0, 3, 50, 60, 10, PACE_FULL, PACE_FULL);
        // Longest lockouts and pulse.
        run_phase(200, 99, 255, 255, 255, 90, 40, 40, PACE_RANDOM, PACE_BURSTY);
        for (int p = 0; p < 6; p++) begin
            run_phase(180, $urandom_range(0, 255), draw_ticks(), draw_ticks(), draw_ticks(),
                      $urandom_range(20, 90), $urandom_range(10, 60),
                      $urandom_range(10, 60), t_pace'(p % 3), t_pace'((p + 1) % 3));
        end
        // Drain to zero, then a maximum of zero that turns every entry away.
        run_phase(150, 99, 0, 0, 4, 60, 10, 70, PACE_BURSTY, PACE_RANDOM);
        run_phase(100, 0, draw_ticks(), draw_ticks(), draw_ticks(), 50, 60, 30,
                  PACE_RANDOM, PACE_FULL);
    endtask

    // Receiver stalls for a long stretch while the sender keeps offering words.
    task automatic hold_receiver(input int n);
        @(posedge i_clk);
        rx_hold = 1'b1;
        repeat (n) @(posedge i_clk);
        rx_hold = 1'b0;
    endtask

    task automatic test_output_backpressure();
        load_settings(99, 1, 1, 4);
        tx_pace = PACE_FULL;
        rx_pace = PACE_FULL;
        fork
            hold_receiver(200);
            repeat (60) drive_word(roll(50), roll(50), roll(40));
        join
        stop_input();
    endtask

    task automatic check_field(input string field, input logic [6:0] want,
                               input logic [6:0] got);
        if (want !== got) begin
            errors++;
            if (errors <= 40)
                $display("%0t: %s mismatch, expected %0d, actual %0d", $time, field, want, got);
        end
    endtask

    // Check each result word against the oldest expectation.
    always @(posedge i_clk) begin
        t_display_word want;
        if (i_rst_n === 1'b1 && out_ch.valid === 1'b1 && out_ch.ready === 1'b1) begin
            if (pending_display_words.size() == 0) begin
                errors++;
                $display("%0t: result word with none expected, expected nothing, actual %0d",
                         $time, out_ch.occupancy);
            end else begin
                want = pending_display_words.pop_front();
                check_field("segments", want.segments, out_ch.segments);
                check_field("tens_enable_n", 7'(want.tens_n), 7'(out_ch.tens_enable_n));
                check_field("units_enable_n", 7'(want.units_n), 7'(out_ch.units_enable_n));
                check_field("gate_on", 7'(want.gate), 7'(out_ch.gate_on));
                check_field("occupancy", want.occupancy, out_ch.occupancy);
                words_checked++;
            end
            rx_wait = draw_gap(rx_pace);
        end
    end

    // Result ready: long hold first, then the drawn wait after each taken word.
    always @(negedge i_clk) begin
        if (rx_hold) begin
            out_ch.ready <= 1'b0;
        end else if (rx_wait > 0) begin
            out_ch.ready <= 1'b0;
            rx_wait = rx_wait - 1;
        end else begin
            out_ch.ready <= 1'b1;
        end
    end

    // Watchdog on the whole run.
    always @(posedge i_clk) begin
        cycles++;
        if (cycles > CycleLimit) begin
            $display("Timeout after %0d cycles with %0d words outstanding.", cycles,
                     pending_display_words.size());
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    initial begin
        i_rst_n           = 1'b0;
        i_cfg_we          = 1'b0;
        i_cfg_index       = CFG_MAX_COUNT;
        i_cfg_data        = '0;
        in_ch.valid       = 1'b0;
        in_ch.tick        = 1'b0;
        in_ch.entry_event = 1'b0;
        in_ch.exit_event  = 1'b0;
        out_ch.ready      = 1'b0;

        cfg_max_count     = MaxCountRst;
        cfg_entry_lockout = EntryLockoutRst;
        cfg_exit_lockout  = ExitLockoutRst;
        cfg_gate_pulse    = GatePulseRst;
        occ_count         = '0;
        gate_left         = '0;
        entry_left        = '0;
        exit_left         = '0;
        show_units        = 1'b0;
        seg_shown         = '0;
        digit_en          = EnOff;
        gate_state        = 1'b0;

        repeat (9) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        test_defaults_after_reset();
        test_lockout_and_pulse();
        test_count_limits();
        test_random_traffic();
        test_output_backpressure();

        settle_block();
        repeat (8) @(posedge i_clk);
        $display("Sent %0d event words under %0d register settings, checked %0d results.",
                 words_sent, settings_loaded, words_checked);
        $display("Peak occupancy %0d; lockouts, gate pulses, limits and stalls exercised.",
                 peak_occupancy);
        if (errors == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("%0d mismatches found.", errors);
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule

`default_nettype wire
